// File: rtl/core/gbc_pkg.sv
package gbc_pkg;

    localparam int MAX_CALIB_SAMPLES = 255;
    localparam int NUM_AXES          = 3;
    localparam int DIV_STEPS         = 24;

    localparam logic       FUNC_MEAS   = 1'b0;
    localparam logic       FUNC_CAL    = 1'b1;
    localparam logic       KIND_MEAS   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [7:0] REG_CALIB_TOTAL = 8'd0;
    localparam logic [7:0] REG_MIN_VALID   = 8'd1;
    localparam logic [7:0] REG_GYRO_SCALE  = 8'd2;
    localparam logic [7:0] REG_ACCEL_SCALE = 8'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } gbc_state_t;

    // per-axis lane controls, issued by the sequencer in the top level
    typedef struct packed {
        logic       capture;
        logic       cal_add;
        logic       end_run;
        logic       div_load;
        logic       div_step;
        logic       bias_clear;
        logic       bias_write;
        logic [7:0] divisor;
    } gbc_lane_ctl_t;

endpackage

// File: rtl/core/gyro_bias_calibrate_correct.sv
// Gyro zero-rate bias calibration and correction. One item at a time: s_tready is high only
// while the block is idle. A measurement item with a good read goes through capture of
// the bias-corrected counts, then the per-axis multipliers into the output register; a
// failed measurement read or a calibration item that does not end the run keeps it idle.
// The item that ends a successful run with good reads goes through capture, 24 steps of
// the per-axis restoring dividers (sum / valid count), and the status write. A failed run
// or one with no good reads skips the divide. Results wait in a one-entry output register,
// so a stall on m_tready holds the block only once a second result is ready. Three axis
// lanes work in parallel; cfg_ready is always high and writes take effect at once.
module gyro_bias_calibrate_correct (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [79:0]   s_tdata,   // read_ok, gyro_x, gyro_y, gyro_z, accel_x/y/z, pad
    input  logic          s_tuser,   // func
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [199:0]  m_tdata,   // calibrated, rate_x, rate_y, rate_z, lin_acc_x/y/z, pad
    output logic          m_tuser,   // result_kind
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    import gbc_pkg::*;

    gbc_state_t    state_reg, state_next;
    logic [7:0]    calib_total_reg;
    logic [7:0]    min_valid_reg;
    logic [23:0]   gyro_scale_reg;
    logic [23:0]   accel_scale_reg;
    logic [7:0]    attempt_cnt_reg, attempt_cnt_next;
    logic [7:0]    valid_cnt_reg, valid_cnt_next;
    logic [7:0]    div_den_reg, div_den_next;
    logic [4:0]    div_cnt_reg, div_cnt_next;
    logic          is_cal_reg, is_cal_next;

    logic          accept;
    logic          read_ok;
    logic [7:0]    attempt_inc;
    logic [7:0]    valid_inc;
    logic [8:0]    total;
    logic          end_run;
    logic          out_ready;
    logic          out_load;
    logic          out_kind;
    gbc_lane_ctl_t lane_ctl;
    logic [2:0][15:0] gyro_in;
    logic [2:0][7:0]  accel_in;
    logic [2:0][31:0] rate;
    logic [2:0][31:0] lin_acc;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign read_ok   = s_tdata[0];

    assign gyro_in[0]  = s_tdata[16:1];
    assign gyro_in[1]  = s_tdata[32:17];
    assign gyro_in[2]  = s_tdata[48:33];
    assign accel_in[0] = s_tdata[56:49];
    assign accel_in[1] = s_tdata[64:57];
    assign accel_in[2] = s_tdata[72:65];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_total_reg <= 8'd100;
            min_valid_reg   <= 8'd90;
            gyro_scale_reg  <= 24'd20497;
            accel_scale_reg <= 24'd11572;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CALIB_TOTAL: calib_total_reg <= cfg_data[7:0];
                REG_MIN_VALID:   min_valid_reg   <= cfg_data[7:0];
                REG_GYRO_SCALE:  gyro_scale_reg  <= cfg_data;
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        total = (calib_total_reg == 8'd0) ? 9'd1 : {1'b0, calib_total_reg};
        if (total > 9'(MAX_CALIB_SAMPLES)) begin
            total = 9'(MAX_CALIB_SAMPLES);
        end
        attempt_inc = attempt_cnt_reg + 8'd1;
        valid_inc   = valid_cnt_reg + {7'd0, read_ok};
        end_run     = ({1'b0, attempt_inc} >= total);
    end

    // s_tready is high in idle, so s_tvalid alone marks an accepted item there
    always_comb begin
        state_next       = state_reg;
        attempt_cnt_next = attempt_cnt_reg;
        valid_cnt_next   = valid_cnt_reg;
        div_den_next     = div_den_reg;
        div_cnt_next     = div_cnt_reg;
        is_cal_next      = is_cal_reg;
        out_load         = 1'b0;
        out_kind         = KIND_MEAS;
        lane_ctl         = '0;
        lane_ctl.divisor = div_den_reg;
        s_tready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready         = 1'b1;
                lane_ctl.capture = s_tvalid;
                if (s_tvalid && s_tuser == FUNC_MEAS) begin
                    if (read_ok) begin
                        state_next = ST_MUL;
                    end
                end else if (s_tvalid) begin
                    lane_ctl.cal_add = read_ok;
                    attempt_cnt_next = attempt_inc;
                    valid_cnt_next   = valid_inc;
                    if (end_run) begin
                        lane_ctl.end_run = 1'b1;
                        attempt_cnt_next = '0;
                        valid_cnt_next   = '0;
                        is_cal_next      = (valid_inc >= min_valid_reg);
                        if (valid_inc < min_valid_reg || valid_inc == 8'd0) begin
                            lane_ctl.bias_clear = 1'b1;
                            state_next          = ST_FIN;
                        end else begin
                            lane_ctl.div_load = 1'b1;
                            div_den_next      = valid_inc;
                            div_cnt_next      = 5'(DIV_STEPS - 1);
                            state_next        = ST_DIV;
                        end
                    end
                end
            end
            ST_MUL: begin
                out_load = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                lane_ctl.div_step = 1'b1;
                div_cnt_next      = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0) begin
                    lane_ctl.bias_write = 1'b1;
                    state_next          = ST_FIN;
                end
            end
            ST_FIN: begin
                out_load = 1'b1;
                out_kind = KIND_STATUS;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            attempt_cnt_reg <= '0;
            valid_cnt_reg   <= '0;
            is_cal_reg      <= 1'b0;
            div_cnt_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            attempt_cnt_reg <= attempt_cnt_next;
            valid_cnt_reg   <= valid_cnt_next;
            is_cal_reg      <= is_cal_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_den_reg <= div_den_next;
    end

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
        gbc_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (lane_ctl),
            .gyro_in     ($signed(gyro_in[k])),
            .accel_in    ($signed(accel_in[k])),
            .gyro_scale  (gyro_scale_reg),
            .accel_scale (accel_scale_reg),
            .rate        (rate[k]),
            .lin_acc     (lin_acc[k])
        );
    end

    gbc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (out_load),
        .kind       (out_kind),
        .calibrated (is_cal_reg),
        .rate       (rate),
        .lin_acc    (lin_acc),
        .ready      (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_valid_le_attempt: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_cnt_reg <= attempt_cnt_reg)
        else $error("valid read count exceeds attempt count");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_den_reg != 8'd0)
        else $error("divide started with zero valid count");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tdata[192:1] == '0)
        else $error("status item carries nonzero rate or acceleration");

    a_meas_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == FUNC_MEAS && read_ok |=> !s_tready && state_reg == ST_MUL)
        else $error("good measurement item did not enter the multiply cycle");

    a_status_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_ready |=> m_tvalid && m_tuser == KIND_STATUS)
        else $error("status item not delivered after run end");

endmodule

// File: rtl/core/gbc_lane.sv
module gbc_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gbc_pkg::gbc_lane_ctl_t ctl,
    input  logic signed [15:0]    gyro_in,
    input  logic signed [7:0]     accel_in,
    input  logic        [23:0]    gyro_scale,
    input  logic        [23:0]    accel_scale,
    output logic        [31:0]    rate,
    output logic        [31:0]    lin_acc
);
    import gbc_pkg::*;

    logic signed [15:0] diff_reg;
    logic signed [7:0]  acc_reg;
    logic signed [23:0] sum_reg;
    logic signed [15:0] bias_reg;
    logic        [7:0]  rem_reg;
    logic        [23:0] quo_reg;
    logic               neg_reg;

    logic signed [23:0] sum_add;
    logic signed [23:0] sum_used;
    logic        [23:0] sum_mag;
    logic        [8:0]  rem_sh;
    logic               ge;
    logic        [8:0]  rem_step;
    logic        [23:0] quo_step;
    logic        [15:0] bias_div;
    logic signed [40:0] gprod;
    logic signed [32:0] aprod;

    always_comb begin
        sum_add  = sum_reg + {{8{gyro_in[15]}}, gyro_in};
        sum_used = ctl.cal_add ? sum_add : sum_reg;
        sum_mag  = sum_used[23] ? (~sum_used + 24'd1) : sum_used;
        // restoring divide, one quotient bit per step
        rem_sh   = {rem_reg, quo_reg[23]};
        ge       = (rem_sh >= {1'b0, ctl.divisor});
        rem_step = ge ? (rem_sh - {1'b0, ctl.divisor}) : rem_sh;
        quo_step = {quo_reg[22:0], ge};
        bias_div = neg_reg ? (~quo_step[15:0] + 16'd1) : quo_step[15:0];
        gprod    = diff_reg * $signed({1'b0, gyro_scale});
        aprod    = acc_reg * $signed({1'b0, accel_scale});
    end

    assign rate    = gprod[39:8];
    assign lin_acc = aprod[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            bias_reg <= '0;
        end else begin
            if (ctl.end_run) begin
                sum_reg <= '0;
            end else if (ctl.cal_add) begin
                sum_reg <= sum_add;
            end
            if (ctl.bias_clear) begin
                bias_reg <= '0;
            end else if (ctl.bias_write) begin
                bias_reg <= bias_div;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            diff_reg <= gyro_in - bias_reg;
            acc_reg  <= accel_in;
        end
        if (ctl.div_load) begin
            quo_reg <= sum_mag;
            neg_reg <= sum_used[23];
            rem_reg <= '0;
        end else if (ctl.div_step) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step[7:0];
        end
    end

endmodule

// File: rtl/core/gbc_merge.sv
module gbc_merge (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic          kind,
    input  logic          calibrated,
    input  logic [2:0][31:0] rate,
    input  logic [2:0][31:0] lin_acc,
    output logic          ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [199:0]  m_tdata,   // calibrated, rate_x, rate_y, rate_z, lin_acc_x/y/z, pad
    output logic          m_tuser    // result_kind
);
    import gbc_pkg::*;

    logic         valid_reg;
    logic [199:0] data_reg;
    logic         user_reg;
    logic [199:0] data_next;

    assign ready = !valid_reg || m_tready;

    always_comb begin
        data_next = '0;
        data_next[0] = calibrated;
        if (kind == KIND_MEAS) begin
            data_next[32:1]    = rate[0];
            data_next[64:33]   = rate[1];
            data_next[96:65]   = rate[2];
            data_next[128:97]  = lin_acc[0];
            data_next[160:129] = lin_acc[1];
            data_next[192:161] = lin_acc[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && load) begin
            data_reg <= data_next;
            user_reg <= kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
